// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, sampled on the rising edge, off while reset is low.
`define KMCD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Condition that must never be seen on an active edge.
`define KMCD_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ===== hdl/kmcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcd_pkg
// Shared types and constants of the key matrix column debounce unit.
// ----------------------------------------------------------------------------
package kmcd_pkg;

    localparam int COL_W  = 3;
    localparam int PIN_W  = 8;
    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd5;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [PIN_W-1:0]  row_levels;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [COL_W-1:0] column_out;
        logic [PIN_W-1:0] pressed;
        logic [PIN_W-1:0] changed;
    } result_t;

endpackage

// ===== hdl/kmcd_state_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcd_state_mem
// Per-column key state memory: one row per column, registered read, write
// forwarding onto a same-row read, and row valid bits so that rows never
// written since reset read as zero.
// ----------------------------------------------------------------------------
module kmcd_state_mem
    import kmcd_pkg::*;
#(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 272
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DW-1:0]    mem_q_reg;
    logic [DW-1:0]    byp_reg;
    logic             sel_byp_reg;
    logic             hit_reg;
    logic [DEPTH-1:0] row_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
            byp_reg   <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            sel_byp_reg   <= 1'b0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                // same-row write on this edge: the array still holds the old row
                sel_byp_reg <= wr_en && (wr_addr == rd_addr);
                hit_reg     <= (wr_en && (wr_addr == rd_addr)) || row_valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = !hit_reg    ? '0      :
                     sel_byp_reg ? byp_reg : mem_q_reg;

endmodule

// ===== hdl/kmcd_row_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcd_row_update
// Debounce update of one column row: every key lane compares its new press
// level with the stored raw level, restamps the change time and promotes
// the level to the debounced state once it has been stable long enough.
// Row layout, high to low: stable bits, last raw bits, change times.
// ----------------------------------------------------------------------------
module kmcd_row_update
    import kmcd_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int DW   = 272
)
(
    input  logic [PIN_W-1:0]  row_levels,
    input  logic [TIME_W-1:0] now_ms,
    input  logic [CFG_W-1:0]  debounce_ms,
    input  logic [DW-1:0]     row_old,
    output logic [DW-1:0]     row_new,
    output logic [PIN_W-1:0]  pressed,
    output logic [PIN_W-1:0]  changed
);

    localparam int RAW_LSB = ROWS * TIME_W;
    localparam int ST_LSB  = RAW_LSB + ROWS;

    logic [ROWS+PIN_W-1:0] press_ext;
    logic [ROWS-1:0]       raw_vec;
    logic [ROWS-1:0]       stable_new;
    logic [ROWS-1:0]       changed_vec;
    logic [ROWS+PIN_W-1:0] stable_ext;
    logic [ROWS+PIN_W-1:0] changed_ext;

    // rows past the pin field read as pressed
    assign press_ext = {{ROWS{1'b1}}, ~row_levels};
    assign raw_vec   = press_ext[ROWS-1:0];

    always_comb
    begin
        logic [TIME_W-1:0] ct;
        logic [TIME_W-1:0] elapsed;
        logic              st;
        row_new     = row_old;
        stable_new  = '0;
        changed_vec = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            ct = row_old[r*TIME_W +: TIME_W];
            st = row_old[ST_LSB + r];
            if (row_old[RAW_LSB + r] != raw_vec[r])
            begin
                ct = now_ms;
            end
            elapsed = now_ms - ct;
            if ((elapsed > TIME_W'(debounce_ms)) && (st != raw_vec[r]))
            begin
                st             = raw_vec[r];
                changed_vec[r] = 1'b1;
            end
            stable_new[r]                  = st;
            row_new[r*TIME_W +: TIME_W]    = ct;
            row_new[RAW_LSB + r]           = raw_vec[r];
            row_new[ST_LSB + r]            = st;
        end
    end

    assign stable_ext  = {{PIN_W{1'b0}}, stable_new};
    assign changed_ext = {{PIN_W{1'b0}}, changed_vec};
    assign pressed     = stable_ext[PIN_W-1:0];
    assign changed     = changed_ext[PIN_W-1:0];

endmodule

// ===== hdl/key_matrix_column_debounce_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_column_debounce_unit
// Per-key debounce for a scanned key matrix, one column sample per transfer.
// ----------------------------------------------------------------------------
// Input channel sample/sample_valid/sample_ready carries the column index, the
// active-low row pin levels and the millisecond time. Output channel
// result/result_valid/result_ready returns the column's debounced key states
// and the mask of keys whose debounced state changed. Columns at or beyond
// COLS leave the state alone and return zero states.
// debounce_we/debounce_wdata set the debounce time; write only while idle.
// A sample is held in the update stage registers and its result then in the
// result register, where it can be taken. One sample per cycle is sustained
// while the receiver does not stall, including repeated samples of the same
// column: the per-column row is read from a memory with a registered read on
// transfer, updated in the update stage and written back, with the written row
// forwarded to a read of the same column on that edge.
// Reset clears all key state (row valid bits) and sets the debounce time to 5.
// When the receiver stalls, the result register holds and the update stage
// holds one more sample; sample_ready then drops until the result is taken.
// ----------------------------------------------------------------------------
module key_matrix_column_debounce_unit
    import kmcd_pkg::*;
#(
    parameter int ROWS = 8,
    parameter int COLS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  sample_t          sample,
    output logic             result_valid,
    input  logic             result_ready,
    output result_t          result,
    input  logic             debounce_we,
    input  logic [CFG_W-1:0] debounce_wdata
);

    localparam int AW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int EW = ROWS * (TIME_W + 2);

    logic             accept;
    logic             advance;
    logic             in_range;
    logic [CFG_W-1:0] debounce_reg;
    logic             s1_valid_reg;
    logic             s1_in_range_reg;
    sample_t          s1_sample_reg;
    logic             result_valid_reg;
    result_t          result_reg;
    result_t          result_next;
    logic [EW-1:0]    row_old;
    logic [EW-1:0]    row_new;
    logic [PIN_W-1:0] upd_pressed;
    logic [PIN_W-1:0] upd_changed;
    logic             wr_en;

    assign advance      = !result_valid_reg || result_ready;
    assign sample_ready = !s1_valid_reg || advance;
    assign accept       = sample_valid && sample_ready;
    assign in_range     = 32'(sample.column) < 32'(COLS);
    assign wr_en        = s1_valid_reg && s1_in_range_reg && advance;

    kmcd_state_mem #(
        .DEPTH (COLS),
        .AW    (AW),
        .DW    (EW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept && in_range),
        .rd_addr (AW'(sample.column)),
        .rd_data (row_old),
        .wr_en   (wr_en),
        .wr_addr (AW'(s1_sample_reg.column)),
        .wr_data (row_new)
    );

    kmcd_row_update #(
        .ROWS (ROWS),
        .DW   (EW)
    ) u_update (
        .row_levels  (s1_sample_reg.row_levels),
        .now_ms      (s1_sample_reg.now_ms),
        .debounce_ms (debounce_reg),
        .row_old     (row_old),
        .row_new     (row_new),
        .pressed     (upd_pressed),
        .changed     (upd_changed)
    );

    always_comb
    begin
        result_next.column_out = s1_sample_reg.column;
        result_next.pressed    = s1_in_range_reg ? upd_pressed : '0;
        result_next.changed    = s1_in_range_reg ? upd_changed : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= DEBOUNCE_RESET;
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (debounce_we)
            begin
                debounce_reg <= debounce_wdata;
            end
            if (sample_ready)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (advance)
            begin
                result_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg   <= sample;
            s1_in_range_reg <= in_range;
        end
        if (advance && s1_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/kmcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmcd_checker
// Port-level checks of the key matrix column debounce unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kmcd_checker
    import kmcd_pkg::*;
#(
    parameter int COLS = 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             sample_valid,
    input logic             sample_ready,
    input logic             result_valid,
    input logic             result_ready,
    input result_t          result,
    input logic             debounce_we
);

    logic cfg_seen;

    assign cfg_seen = debounce_we;

    // a pending result stays up with the same payload until taken
    `KMCD_ASSERT(a_result_hold, clk, rst_n,
        (result_valid && !result_ready) |=> (result_valid && $stable(result)))

    // a fresh result follows a sample transfer through the update and result registers
    `KMCD_ASSERT(a_result_origin, clk, rst_n,
        $rose(result_valid) |-> $past(sample_valid && sample_ready, 2))

    // an empty output register never blocks the input side
    `KMCD_ASSERT(a_ready_when_empty, clk, rst_n,
        !result_valid |-> sample_ready)

    // columns outside the matrix report no keys
    `KMCD_ASSERT_NEVER(a_out_of_range_zero, clk, rst_n,
        result_valid && (32'(result.column_out) >= 32'(COLS)) &&
        ((result.pressed != '0) || (result.changed != '0)))

    // debounce writes happen while no result is pending
    `KMCD_ASSERT_NEVER(a_cfg_while_busy, clk, rst_n,
        cfg_seen && result_valid)

endmodule

bind key_matrix_column_debounce_unit kmcd_checker #(.COLS(COLS)) u_kmcd_checker (.*);

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the key matrix column debounce unit.
// ----------------------------------------------------------------------------
// Column samples are sent over the sample channel with random gaps. A per-key
// debounce predictor works out the expected column states for each sample
// transfer. Results arrive under random receiver stalls and are checked field
// by field in order. The run steps through several debounce settings: reset
// value, zero, one, maximum and random values. Bounce and timing near the
// debounce edge are exercised, and so is wrap of the millisecond time.
// ----------------------------------------------------------------------------
module tb_top;
    import kmcd_pkg::*;

    localparam int KEYS        = 64;
    localparam int PHASE_ITEMS = 310;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 sample_valid   = 1'b0;
    logic                 sample_ready;
    sample_t              sample         = '0;
    logic                 result_valid;
    logic                 result_ready   = 1'b0;
    result_t              result;
    logic                 debounce_we    = 1'b0;
    logic [CFG_W-1:0]     debounce_wdata = '0;

    // predictor state
    logic                 key_raw       [KEYS] = '{default: 1'b0};
    logic [TIME_W-1:0]    key_change_ms [KEYS] = '{default: '0};
    logic                 key_stable    [KEYS] = '{default: 1'b0};
    logic [CFG_W-1:0]     debounce_cfg = DEBOUNCE_RESET;

    sample_t              pending_samples [$];
    result_t              column_states_q [$];

    // stimulus generator state
    logic [TIME_W-1:0]    clock_ms = '0;
    logic [COL_W-1:0]     scan_col = '0;
    logic [PIN_W-1:0]     held_rows [8] = '{default: 8'hFF};

    int src_gap       = 0;
    int src_calm      = 0;
    int sink_hold     = 0;
    int sink_calm     = 0;
    int cycle_count   = 0;
    int fail_count    = 0;
    int samples_sent  = 0;
    int results_seen  = 0;
    int settings_used = 1;

    key_matrix_column_debounce_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_ready   (sample_ready),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .debounce_we    (debounce_we),
        .debounce_wdata (debounce_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, and now and then a calm stretch.
    function automatic int pick_gap(inout int calm);
        int p;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 199) == 0)
            calm = $urandom_range(30, 90);
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        if (p < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic predict_column(input sample_t s);
        result_t           r;
        int                k;
        logic              raw;
        logic [TIME_W-1:0] elapsed;
        r.column_out = s.column;
        r.pressed    = '0;
        r.changed    = '0;
        for (int row = 0; row < 8; row++)
        begin
            k   = int'(s.column) * 8 + row;
            raw = ~s.row_levels[row];
            if (key_raw[k] != raw)
                key_change_ms[k] = s.now_ms;
            key_raw[k] = raw;
            elapsed = s.now_ms - key_change_ms[k];
            if (elapsed > TIME_W'(debounce_cfg) && key_stable[k] != raw)
            begin
                key_stable[k]  = raw;
                r.changed[row] = 1'b1;
            end
            r.pressed[row] = key_stable[k];
        end
        column_states_q.push_back(r);
    endtask

    // sample driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_valid && sample_ready)
            begin
                predict_column(sample);
                samples_sent++;
            end
            if (!sample_valid || sample_ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    sample_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    sample       <= pending_samples.pop_front();
                    sample_valid <= 1'b1;
                    src_gap = pick_gap(src_calm);
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (column_states_q.size() == 0)
                begin
                    $error("result transfer with no expected result pending");
                    fail_count++;
                end
                else
                begin
                    want = column_states_q.pop_front();
                    if (result.column_out !== want.column_out)
                    begin
                        $error("column_out expected %0d actual %0d",
                               want.column_out, result.column_out);
                        fail_count++;
                    end
                    if (result.pressed !== want.pressed)
                    begin
                        $error("pressed expected %02h actual %02h",
                               want.pressed, result.pressed);
                        fail_count++;
                    end
                    if (result.changed !== want.changed)
                    begin
                        $error("changed expected %02h actual %02h",
                               want.changed, result.changed);
                        fail_count++;
                    end
                end
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                sink_hold = pick_gap(sink_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("key_matrix_column_debounce_unit verification failed");
            $finish;
        end
    end

    task automatic queue_sample(input logic [COL_W-1:0] col, input logic [PIN_W-1:0] levels,
                                input logic [TIME_W-1:0] now);
        sample_t s;
        s.column     = col;
        s.row_levels = levels;
        s.now_ms     = now;
        pending_samples.push_back(s);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || sample_valid || column_states_q.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_debounce(input logic [CFG_W-1:0] value);
        wait_drained();
        @(posedge clk);
        debounce_we    <= 1'b1;
        debounce_wdata <= value;
        @(posedge clk);
        debounce_we  <= 1'b0;
        debounce_cfg = value;
        settings_used++;
        @(negedge clk);
    endtask

    // Column scan with held key patterns, contact bounce and time steps that
    // cluster around the debounce edge.
    task automatic build_scan_phase(input int count);
        int                p;
        logic [TIME_W-1:0] step;
        logic [PIN_W-1:0]  levels;
        for (int i = 0; i < count; i++)
        begin
            p = $urandom_range(0, 9);
            if (p == 0)
                scan_col = COL_W'($urandom_range(0, 7));
            else if (p > 1)
                scan_col = scan_col + 1'b1;
            p = $urandom_range(0, 99);
            if (p < 50)
                step = '0;
            else if (p < 80)
                step = $urandom_range(1, 3);
            else if (p < 92)
                step = TIME_W'(debounce_cfg) + $urandom_range(0, 2);
            else if (p < 97)
                step = $urandom_range(4, 40);
            else
                step = $urandom;
            clock_ms = clock_ms + step;
            if ($urandom_range(0, 19) == 0)
                held_rows[scan_col] = held_rows[scan_col] ^ PIN_W'($urandom & $urandom);
            levels = held_rows[scan_col];
            if ($urandom_range(0, 5) == 0)
                levels = levels ^ PIN_W'($urandom & $urandom);
            queue_sample(scan_col, levels, clock_ms);
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] plan [5];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: press and release at the debounce edge, time wrap, bounce
        queue_sample(3'd0, 8'hFF, 32'd0);
        queue_sample(3'd0, 8'h00, 32'd10);
        queue_sample(3'd0, 8'h00, 32'd15);
        queue_sample(3'd0, 8'h00, 32'd16);
        queue_sample(3'd0, 8'hFF, 32'd17);
        queue_sample(3'd0, 8'hFF, 32'd22);
        queue_sample(3'd0, 8'hFF, 32'd23);
        queue_sample(3'd7, 8'h5A, 32'hFFFF_FFFE);
        queue_sample(3'd7, 8'h5A, 32'hFFFF_FFFF);
        queue_sample(3'd7, 8'h5A, 32'd4);
        queue_sample(3'd3, 8'h00, 32'd100);
        queue_sample(3'd3, 8'hFF, 32'd102);
        queue_sample(3'd3, 8'h00, 32'd104);
        queue_sample(3'd3, 8'h00, 32'd109);
        queue_sample(3'd3, 8'h00, 32'd110);
        for (int c = 0; c < 8; c++)
            queue_sample(COL_W'(c), ~(PIN_W'(1) << c), 32'd200);
        queue_sample(3'd1, 8'hFD, 32'd300);

        clock_ms = 32'd1000;
        build_scan_phase(PHASE_ITEMS);

        plan[0] = 16'd0;
        plan[1] = 16'd1;
        plan[2] = 16'hFFFF;
        plan[3] = CFG_W'($urandom);
        plan[4] = CFG_W'($urandom_range(2, 300));
        for (int i = 0; i < 5; i++)
        begin
            write_debounce(plan[i]);
            if (i == 1)
                clock_ms = 32'hFFFF_FF00;
            build_scan_phase(PHASE_ITEMS);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (column_states_q.size() != 0)
        begin
            $error("%0d expected results never arrived", column_states_q.size());
            fail_count++;
        end

        $display("run covered %0d column samples and %0d results under %0d debounce settings",
                 samples_sent, results_seen, settings_used);
        $display("settings included 0, 1, 65535 and random values; time wrap and bounce hit");
        if (fail_count == 0)
            $display("key_matrix_column_debounce_unit verification clean");
        else
            $display("key_matrix_column_debounce_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/kmcd_pkg.sv
hdl/kmcd_state_mem.sv
hdl/kmcd_row_update.sv
hdl/key_matrix_column_debounce_unit.sv
hdl/kmcd_checker.sv
verif/tb_top.sv
